FILE: rtl/twctl_pkg.sv
// shared constants and types of the two-way cache tag lookup
package twctl_pkg;

   localparam int unsigned ADDR_W         = 32;
   localparam int unsigned DEF_NUM_SETS   = 64;
   localparam int unsigned DEF_LINE_BYTES = 32;

   // outcome of one lookup, from the way select logic to the pipeline
   typedef struct packed {
      logic hit;
      logic miss;
      logic way;
      logic replaced_valid;
   } lkp_status_type;

endpackage

FILE: rtl/twctl_tag_ram.sv
// single-port-write, single-port-read set memory with registered read data
module twctl_tag_ram #(
   parameter int unsigned DEPTH = 64,
   parameter int unsigned WIDTH = 45,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read before write on the same address
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/twctl_way_select.sv
// hit check over both ways, fill choice and updated set entry
module twctl_way_select #(
   parameter int unsigned TAG_W  = 21,
   localparam int unsigned ENT_W = 2 * TAG_W + 3
) (
   input  logic [ENT_W-1:0]          entry,
   input  logic [TAG_W-1:0]          tag,
   output twctl_pkg::lkp_status_type status,
   output logic [TAG_W-1:0]          evicted_tag,
   output logic [ENT_W-1:0]          next_entry
);

   import twctl_pkg::*;

   logic [TAG_W-1:0] tag0;
   logic [TAG_W-1:0] tag1;
   logic [1:0]       valid;
   logic             lru;
   logic             hit0;
   logic             hit1;
   logic             miss;
   logic             way;
   logic             repl;
   logic [TAG_W-1:0] new_tag0;
   logic [TAG_W-1:0] new_tag1;
   logic [1:0]       new_valid;

   // entry layout: {lru, valid[1:0], tag of way 1, tag of way 0}
   assign tag0  = entry[TAG_W-1:0];
   assign tag1  = entry[2*TAG_W-1:TAG_W];
   assign valid = entry[2*TAG_W+1:2*TAG_W];
   assign lru   = entry[2*TAG_W+2];

   always_comb begin
      hit0 = valid[0] && (tag0 == tag);
      hit1 = !hit0 && valid[1] && (tag1 == tag);
      miss = !hit0 && !hit1;
      way  = hit0 ? 1'b0 : (hit1 ? 1'b1 : lru);
      repl = miss && (way ? valid[1] : valid[0]);

      evicted_tag = '0;
      if (repl) begin
         evicted_tag = way ? tag1 : tag0;
      end

      new_tag0  = tag0;
      new_tag1  = tag1;
      new_valid = valid;
      if (miss) begin
         if (way) begin
            new_tag1     = tag;
            new_valid[1] = 1'b1;
         end else begin
            new_tag0     = tag;
            new_valid[0] = 1'b1;
         end
      end

      next_entry = {~way, new_valid, new_tag1, new_tag0};

      status.hit            = !miss;
      status.miss           = miss;
      status.way            = way;
      status.replaced_valid = repl;
   end

endmodule

FILE: rtl/two_way_cache_tag_lookup.sv
// top level of the two-way cache tag lookup: pipeline, set clear and result register
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   req     | req_valid/ready, req_address   | in
//   rsp     | rsp_valid/ready, rsp_* fields  | out
//
// one word per cycle sustained while rsp_ready stays high; a result passes the lookup
// stage and the result register, with one read-modify-write of the set memory per lookup
// back-to-back words to the same set use the forwarded entry of the one before
// after reset a clear pass over all NUM_SETS sets zeroes valid and lru bits,
// req_ready stays low during it
// rsp_ready low holds the lookup stage and, once it is full, holds off requests
module two_way_cache_tag_lookup #(
   parameter int unsigned NUM_SETS   = twctl_pkg::DEF_NUM_SETS,
   parameter int unsigned LINE_BYTES = twctl_pkg::DEF_LINE_BYTES,
   localparam int unsigned OFFS_W    = $clog2(LINE_BYTES),
   localparam int unsigned SET_W     = $clog2(NUM_SETS),
   localparam int unsigned BLK_W     = twctl_pkg::ADDR_W - OFFS_W,
   localparam int unsigned TAG_W     = twctl_pkg::ADDR_W - OFFS_W - SET_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [twctl_pkg::ADDR_W-1:0] req_address,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [OFFS_W-1:0]            rsp_byte_offset,
   output logic [BLK_W-1:0]             rsp_block_number,
   output logic [SET_W-1:0]             rsp_set_index,
   output logic                         rsp_way,
   output logic [TAG_W-1:0]             rsp_tag,
   output logic                         rsp_miss,
   output logic                         rsp_replaced_valid,
   output logic [TAG_W-1:0]             rsp_evicted_tag
);

   import twctl_pkg::*;

   localparam int unsigned ENT_W = 2 * TAG_W + 3;
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);

   logic                clearing_ff;
   logic [SET_W-1:0]    clr_idx_ff;
   logic                s1_valid_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                fwd_ff;
   logic [ENT_W-1:0]    fwd_entry_ff;
   logic                rsp_valid_ff;
   logic [OFFS_W-1:0]   offs_ff;
   logic [BLK_W-1:0]    block_ff;
   logic [SET_W-1:0]    set_ff;
   logic                way_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic                miss_ff;
   logic                repl_ff;
   logic [TAG_W-1:0]    evicted_ff;

   logic                accept;
   logic                s1_adv;
   logic [SET_W-1:0]    req_set;
   logic [SET_W-1:0]    s1_set;
   logic [TAG_W-1:0]    s1_tag;
   logic [ENT_W-1:0]    rd_entry;
   logic [ENT_W-1:0]    cur_entry;
   logic [ENT_W-1:0]    next_entry;
   logic [TAG_W-1:0]    evicted_tag;
   lkp_status_type      status;
   logic                wr_en;
   logic [SET_W-1:0]    wr_addr;
   logic [ENT_W-1:0]    wr_data;
   logic                fwd_in;

   assign req_set = req_address[OFFS_W+SET_W-1:OFFS_W];
   assign s1_set  = s1_addr_ff[OFFS_W+SET_W-1:OFFS_W];
   assign s1_tag  = s1_addr_ff[ADDR_W-1:OFFS_W+SET_W];

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept    = req_valid && req_ready;

   // the entry written this cycle has not reached the memory read of the next word
   assign cur_entry = fwd_ff ? fwd_entry_ff : rd_entry;

   assign wr_en   = clearing_ff || s1_adv;
   assign wr_addr = clearing_ff ? clr_idx_ff : s1_set;
   assign wr_data = clearing_ff ? '0 : next_entry;
   assign fwd_in  = s1_adv && (req_set == s1_set);

   twctl_tag_ram #(
      .DEPTH (NUM_SETS),
      .WIDTH (ENT_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (rd_entry)
   );

   twctl_way_select #(
      .TAG_W (TAG_W)
   ) u_sel (
      .entry       (cur_entry),
      .tag         (s1_tag),
      .status      (status),
      .evicted_tag (evicted_tag),
      .next_entry  (next_entry)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_idx_ff <= clr_idx_ff + 1'b1;
            if (clr_idx_ff == LAST_SET) begin
               clearing_ff <= 1'b0;
            end
         end

         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= fwd_in;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end

         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff   <= req_address;
         fwd_entry_ff <= next_entry;
      end
      if (s1_adv) begin
         offs_ff    <= s1_addr_ff[OFFS_W-1:0];
         block_ff   <= s1_addr_ff[ADDR_W-1:OFFS_W];
         set_ff     <= s1_set;
         way_ff     <= status.way;
         tag_ff     <= s1_tag;
         miss_ff    <= status.miss;
         repl_ff    <= status.replaced_valid;
         evicted_ff <= evicted_tag;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_offset    = offs_ff;
   assign rsp_block_number   = block_ff;
   assign rsp_set_index      = set_ff;
   assign rsp_way            = way_ff;
   assign rsp_tag            = tag_ff;
   assign rsp_miss           = miss_ff;
   assign rsp_replaced_valid = repl_ff;
   assign rsp_evicted_tag    = evicted_ff;

`ifndef ASSERT_OFF
   // no lookup may start before the clear pass is through
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !accept)
      else $error("request taken during clear pass");

   // a forwarded entry only ever belongs to a word in the lookup stage
   a_fwd_has_owner: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_valid_ff)
      else $error("forward flag set with empty lookup stage");

   // a finished lookup is shown in the next cycle
   a_adv_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("lookup result lost");

   // a hit never reports an eviction
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_miss) |-> (!rsp_replaced_valid && rsp_evicted_tag == '0))
      else $error("eviction reported on hit");
`endif

endmodule

FILE: tb/two_way_cache_tag_lookup_test.sv
// testbench of the two-way cache tag lookup: queued driver, clocked monitor, lru predictor
`timescale 1ns / 100ps

module two_way_cache_tag_lookup_test;

   localparam int unsigned ADDR_W    = twctl_pkg::ADDR_W;
   localparam int unsigned NUM_SETS  = twctl_pkg::DEF_NUM_SETS;
   localparam int unsigned OFFS_W    = $clog2(twctl_pkg::DEF_LINE_BYTES);
   localparam int unsigned SET_W     = $clog2(twctl_pkg::DEF_NUM_SETS);
   localparam int unsigned BLK_W     = ADDR_W - OFFS_W;
   localparam int unsigned TAG_W     = ADDR_W - OFFS_W - SET_W;
   localparam int unsigned RAND_REFS = 500;
   localparam int unsigned LONG_HOLD = 200;
   localparam int unsigned IDLE_LIMIT = 2000;

   typedef struct {
      logic [ADDR_W-1:0] address;
      int unsigned       gap;
   } ref_item_type;

   typedef struct {
      logic [OFFS_W-1:0] byte_offset;
      logic [BLK_W-1:0]  block_number;
      logic [SET_W-1:0]  set_index;
      logic              way;
      logic [TAG_W-1:0]  tag;
      logic              miss;
      logic              replaced_valid;
      logic [TAG_W-1:0]  evicted_tag;
   } lookup_word_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [ADDR_W-1:0]   req_address = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [OFFS_W-1:0]   rsp_byte_offset;
   logic [BLK_W-1:0]    rsp_block_number;
   logic [SET_W-1:0]    rsp_set_index;
   logic                rsp_way;
   logic [TAG_W-1:0]    rsp_tag;
   logic                rsp_miss;
   logic                rsp_replaced_valid;
   logic [TAG_W-1:0]    rsp_evicted_tag;

   // shadow tag directory
   logic [TAG_W-1:0]    dir_tag [NUM_SETS][2];
   logic [1:0]          dir_valid [NUM_SETS];
   logic                dir_lru [NUM_SETS];

   ref_item_type        pending_refs[$];
   lookup_word_type     pending_results[$];
   ref_item_type        staged_ref;
   bit                  staged = 1'b0;
   int unsigned         send_wait = 0;
   int unsigned         hold_cnt = 0;
   int unsigned         results_seen = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         mismatches = 0;
   logic                req_took = 1'b0;
   logic                rsp_took = 1'b0;

   two_way_cache_tag_lookup i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_byte_offset    (rsp_byte_offset),
      .rsp_block_number   (rsp_block_number),
      .rsp_set_index      (rsp_set_index),
      .rsp_way            (rsp_way),
      .rsp_tag            (rsp_tag),
      .rsp_miss           (rsp_miss),
      .rsp_replaced_valid (rsp_replaced_valid),
      .rsp_evicted_tag    (rsp_evicted_tag)
   );

   always #5 clock = ~clock;

   // looks one address up in the shadow directory and updates it
   function automatic lookup_word_type predict_lookup(logic [ADDR_W-1:0] address);
      lookup_word_type  r;
      logic [SET_W-1:0] s;
      logic [1:0]       v;
      r.byte_offset    = address[OFFS_W-1:0];
      r.block_number   = address[ADDR_W-1:OFFS_W];
      r.set_index      = address[OFFS_W+SET_W-1:OFFS_W];
      r.tag            = address[ADDR_W-1:OFFS_W+SET_W];
      r.miss           = 1'b0;
      r.replaced_valid = 1'b0;
      r.evicted_tag    = '0;
      s = r.set_index;
      v = dir_valid[s];
      if (v[0] && dir_tag[s][0] == r.tag) begin
         r.way = 1'b0;
         dir_lru[s] = 1'b1;
      end else if (v[1] && dir_tag[s][1] == r.tag) begin
         r.way = 1'b1;
         dir_lru[s] = 1'b0;
      end else begin
         // fill the lru way, whatever the other way holds
         r.miss = 1'b1;
         r.way  = dir_lru[s];
         if (v[r.way]) begin
            r.replaced_valid = 1'b1;
            r.evicted_tag    = dir_tag[s][r.way];
         end
         dir_tag[s][r.way] = r.tag;
         v[r.way] = 1'b1;
         dir_valid[s] = v;
         dir_lru[s] = ~r.way;
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic logic [ADDR_W-1:0] make_address(logic [TAG_W-1:0] tag,
                                                      logic [SET_W-1:0] set_no,
                                                      logic [OFFS_W-1:0] offs);
      return {tag, set_no, offs};
   endfunction

   task automatic queue_ref(logic [ADDR_W-1:0] address, int unsigned gap);
      ref_item_type it;
      it.address = address;
      it.gap     = gap;
      pending_refs.push_back(it);
   endtask

   // request driver: one word at a time, with a drawn wait before each
   always @(negedge clock) begin : drive_req
      logic              nv;
      logic [ADDR_W-1:0] na;
      nv = req_valid;
      na = req_address;
      if (reset) begin
         nv = 1'b0;
      end else if (!req_valid || req_took) begin
         nv = 1'b0;
         if (!staged && pending_refs.size() != 0) begin
            staged_ref = pending_refs.pop_front();
            staged     = 1'b1;
            send_wait  = staged_ref.gap;
         end
         if (staged) begin
            if (send_wait == 0) begin
               nv     = 1'b1;
               na     = staged_ref.address;
               staged = 1'b0;
            end else begin
               send_wait--;
            end
         end
      end
      req_valid   <= nv;
      req_address <= na;
   end

   // result receiver: random holds, two long ones to back the pipeline up
   always @(negedge clock) begin : drive_rsp
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_took) begin
            results_seen++;
            if (results_seen == 150 || results_seen == 400) begin
               hold_cnt = LONG_HOLD;
            end else if ((results_seen / 50) % 3 == 1) begin
               hold_cnt = 0;
            end else begin
               hold_cnt = $urandom_range(0, 7);
            end
         end
         if (hold_cnt > 0) begin
            rsp_ready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: check the taken result first, then predict the taken request
   always @(posedge clock) begin : watch_rsp
      lookup_word_type want;
      req_took <= req_valid && req_ready;
      rsp_took <= rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected");
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               check_field("byte_offset", 32'(want.byte_offset), 32'(rsp_byte_offset));
               check_field("block_number", 32'(want.block_number),
                           32'(rsp_block_number));
               check_field("set_index", 32'(want.set_index), 32'(rsp_set_index));
               check_field("way", 32'(want.way), 32'(rsp_way));
               check_field("tag", 32'(want.tag), 32'(rsp_tag));
               check_field("miss", 32'(want.miss), 32'(rsp_miss));
               check_field("replaced_valid", 32'(want.replaced_valid),
                           32'(rsp_replaced_valid));
               check_field("evicted_tag", 32'(want.evicted_tag), 32'(rsp_evicted_tag));
            end
         end
         if (req_valid && req_ready) begin
            pending_results.push_back(predict_lookup(req_address));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("two_way_cache_tag_lookup_test: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      logic [SET_W-1:0]  set_pool [4];
      logic [TAG_W-1:0]  tag_pool [4];
      logic [ADDR_W-1:0] last_addr;
      int unsigned       kind;
      int unsigned       gap;

      for (int s = 0; s < NUM_SETS; s++) begin
         dir_tag[s][0] = '0;
         dir_tag[s][1] = '0;
         dir_valid[s]  = '0;
         dir_lru[s]    = 1'b0;
      end

      // directed: extremes, hits on both ways, fills of empty ways, evictions
      queue_ref(make_address('0, '0, '0), 0);
      queue_ref('1, 0);
      queue_ref(make_address('0, '0, '1), 0);
      queue_ref(make_address('1, '0, '0), 0);
      queue_ref(make_address('0, '0, 5'd5), 3);
      queue_ref(make_address('1, '0, 5'd7), 0);
      // evicts a valid line whose tag is zero
      queue_ref(make_address(21'h12345, '0, 5'd0), 0);
      queue_ref(make_address('1, '0, 5'd0), 1);
      queue_ref(make_address(21'h0aaaaa, '0, 5'd0), 0);
      queue_ref(make_address(21'h155555, '1, 5'd0), 0);
      queue_ref(make_address('1, '1, '1), 2);
      queue_ref(make_address('0, '1, 5'd0), 0);
      // back-to-back words on one set
      queue_ref(make_address(21'd3, 6'd21, 5'd0), 0);
      queue_ref(make_address(21'd3, 6'd21, 5'd1), 0);
      queue_ref(make_address(21'd4, 6'd21, 5'd2), 0);
      queue_ref(make_address(21'd5, 6'd21, 5'd3), 0);
      queue_ref(make_address(21'd4, 6'd21, 5'd4), 0);
      queue_ref(make_address(21'd3, 6'd21, 5'd5), 0);
      queue_ref(make_address(21'd4, 6'd42, 5'd6), 5);
      queue_ref(make_address(21'd4, 6'd21, 5'd7), 0);

      last_addr = '0;
      for (int unsigned i = 0; i < RAND_REFS; i++) begin
         if (i % 40 == 0) begin
            for (int k = 0; k < 4; k++) begin
               set_pool[k] = SET_W'($urandom_range(0, NUM_SETS - 1));
               tag_pool[k] = TAG_W'($urandom);
            end
            // a few small sets and tags per phase keep hits and evictions frequent
            set_pool[0] = $urandom_range(0, 1) ? set_pool[1] : set_pool[0];
         end
         gap  = ((i / 40) % 3 == 0) ? 0 : $urandom_range(0, 7);
         kind = $urandom_range(0, 99);
         if (kind < 12) begin
            last_addr = $urandom;
         end else if (kind < 22) begin
            last_addr[OFFS_W-1:0] = OFFS_W'($urandom);
            gap = 0;
         end else begin
            last_addr = make_address(tag_pool[$urandom_range(0, 3)],
                                     set_pool[$urandom_range(0, 3)], OFFS_W'($urandom));
         end
         queue_ref(last_addr, gap);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_refs.size() != 0 || staged || req_valid ||
             pending_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);

      if (mismatches == 0) begin
         $display("two_way_cache_tag_lookup_test: done, clean");
      end else begin
         $display("two_way_cache_tag_lookup_test: done, errors");
      end
      $finish;
   end

endmodule
